// ===== sv/integer_to_ascii_radix_assert.svh =====
// Assertion shorthands used by the RTL datapath (i2a_dp).
// Both expect clk and arst_n in scope.
`ifndef INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_ASSERT_SVH

// Same-cycle implication
`define I2A_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/i2a_pkg.sv =====
`timescale 1ns / 1ps
package i2a_pkg;

	// Input integer width
	localparam int VALUE_WIDTH = 32;
	localparam int S_TDATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;

	// Radix register
	localparam int RADIX_W = 6;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] DECIMAL     = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] TOP_NUMERIC = RADIX_W'(9);

	// Characters
	localparam int CHAR_W = 8;
	localparam logic [CHAR_W-1:0] CHR_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CHR_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHR_MINUS   = 8'h2D;

	// Divider: DIV_BITS quotient bits per cycle
	localparam int DIV_BITS   = 8;
	localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_W      = DIV_CYCLES * DIV_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

	// Character stack: base 2 gives the longest text
	localparam int STACK_DEPTH = VALUE_WIDTH;
	localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic push_digit;
		logic push_minus;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic quot_zero;
		logic neg;
		logic stack_last;
		logic out_free;
	} status_t;

	// Digit value to ASCII
	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] r;
		if (d > TOP_NUMERIC) begin
			r = CHAR_W'(d - DECIMAL) + CHR_LOWER_A;
		end else begin
			r = CHAR_W'(d) + CHR_ZERO;
		end
		return r;
	endfunction

endpackage

// ===== sv/i2a_ctrl.sv =====
`timescale 1ns / 1ps
module i2a_ctrl import i2a_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q, state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nx = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) state_nx = ST_PUSH;
			end
			ST_PUSH: begin
				if (!sts.quot_zero) state_nx = ST_DIV;
				else if (sts.neg) state_nx = ST_SIGN;
				else state_nx = ST_EMIT;
			end
			ST_SIGN: begin
				state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free && sts.stack_last) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_PUSH: begin
				cmd.push_digit = 1'b1;
			end
			ST_SIGN: begin
				cmd.push_minus = 1'b1;
			end
			ST_EMIT: begin
				cmd.pop = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== sv/i2a_dp.sv =====
`timescale 1ns / 1ps
`include "integer_to_ascii_radix_assert.svh"
module i2a_dp import i2a_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [RADIX_W-1:0]          cfg_data,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  cmd_t                        cmd,
	output status_t                     sts,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [CHAR_W-1:0]           m_tdata,
	output logic                        m_tlast
);

	logic [RADIX_W-1:0]     radix_q;
	logic [RADIX_W-1:0]     base_q;
	logic [RADIX_W-1:0]     base_eff;
	logic                   neg_q;
	logic [DIV_W-1:0]       div_q, div_nx;
	logic [RADIX_W-1:0]     rem_q, rem_nx;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [CHAR_W-1:0]      stk_q [STACK_DEPTH];
	logic [STACK_CNT_W-1:0] sc_q;
	logic [CHAR_W-1:0]      push_chr;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   is_neg10;
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      out_chr_q;
	logic                   out_last_q;

	// Radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid) begin
			radix_q <= cfg_data;
		end
	end

	// Saturate the radix to 2..36
	always_comb begin
		base_eff = radix_q;
		if (radix_q < RADIX_MIN) base_eff = RADIX_MIN;
		if (radix_q > RADIX_MAX) base_eff = RADIX_MAX;
	end

	// Only decimal gets a sign; magnitude of the most negative value wraps to 2^(W-1)
	assign is_neg10 = (base_eff == DECIMAL) && value[VALUE_WIDTH-1];
	assign mag = is_neg10 ? (~value + 1'b1) : value;

	// Restoring division, DIV_BITS quotient bits per cycle
	always_comb begin : div_step
		logic [RADIX_W:0] t;
		logic [RADIX_W-1:0] r;
		logic [DIV_W-1:0] d;
		r = rem_q;
		d = div_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r, d[DIV_W-1]};
			d = {d[DIV_W-2:0], 1'b0};
			if (t >= {1'b0, base_q}) begin
				t = t - {1'b0, base_q};
				d[0] = 1'b1;
			end
			r = t[RADIX_W-1:0];
		end
		div_nx = d;
		rem_nx = r;
	end

	// Dividend/quotient, remainder and step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load || cmd.push_digit) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_q  <= DIV_W'(mag);
			rem_q  <= '0;
			base_q <= base_eff;
			neg_q  <= is_neg10;
		end else if (cmd.div_step) begin
			div_q <= div_nx;
			rem_q <= rem_nx;
		end else if (cmd.push_digit) begin
			rem_q <= '0;
		end
	end

	// Character stack; top is entry 0
	assign push_chr = cmd.push_minus ? CHR_MINUS : digit_char(rem_q);

	always_ff @(posedge clk) begin
		if (cmd.push_digit || cmd.push_minus) begin
			stk_q[0] <= push_chr;
			for (int i = 1; i < STACK_DEPTH; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < STACK_DEPTH - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q <= '0;
		end else if (cmd.push_digit || cmd.push_minus) begin
			sc_q <= sc_q + 1'b1;
		end else if (cmd.pop) begin
			sc_q <= sc_q - 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_chr_q  <= stk_q[0];
			out_last_q <= (sc_q == STACK_CNT_W'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_chr_q;
	assign m_tlast  = out_last_q;

	// Status to the controller
	assign sts.div_last   = (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1));
	assign sts.quot_zero  = (div_q == '0);
	assign sts.neg        = neg_q;
	assign sts.stack_last = (sc_q == STACK_CNT_W'(1));
	assign sts.out_free   = !out_valid_q || m_tready;

	`I2A_ASSERT_NOW(a_pop_nonempty, cmd.pop, sc_q != '0, "pop from empty stack")
	`I2A_ASSERT_NOW(a_push_room, cmd.push_digit || cmd.push_minus, sc_q != STACK_CNT_W'(STACK_DEPTH), "push to full stack")
	`I2A_ASSERT_NOW(a_minus_only_neg, cmd.push_minus, neg_q && base_q == DECIMAL, "sign without negative decimal")
	`I2A_ASSERT_NEXT(a_last_pop_empties, cmd.pop && sc_q == STACK_CNT_W'(1), sc_q == '0 && m_tlast, "last character not flagged")

endmodule

// ===== sv/integer_to_ascii_radix.sv =====
`timescale 1ns / 1ps
// Integer to text converter. Each word on s_tdata is a signed 32-bit integer; the block
// returns its text in the base held by the radix register (2..36, reset 10, values
// outside that range saturate), one ASCII character per output word, most significant
// first, with m_tlast on the final character. Digits above nine are lower-case letters,
// zero gives "0", and only base 10 writes a negative value as '-' and its magnitude;
// other bases print the raw two's-complement pattern. For each digit the shared radix
// divider runs over the 32-bit word, eight quotient bits per cycle, and the character
// is then pushed on the output stack; a decimal sign is pushed after the last digit,
// and the characters then leave at one per cycle when m_tready is high. s_tready is
// high only between items; the last character may still wait in the output register
// while the next integer is taken. Write the radix on the cfg port only when the block is idle.
module integer_to_ascii_radix import i2a_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [RADIX_W-1:0]   cfg_data,   // radix
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,    // value (signed)
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [CHAR_W-1:0]    m_tdata,    // character
	output logic                 m_tlast     // last_char
);

	cmd_t    cmd;
	status_t sts;

	assign cfg_ready = 1'b1;

	i2a_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	i2a_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.value     (s_tdata[VALUE_WIDTH-1:0]),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import i2a_pkg::*;

	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 250;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 16;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_char_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [RADIX_W-1:0]   cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [CHAR_W-1:0]    m_tdata;
	logic                 m_tlast;

	// predictor copy of the radix register and the characters still owed
	logic [RADIX_W-1:0] radix_copy;
	text_char_t         pending_chars[$];

	int  err_count;
	int  tx_gap_max;
	int  rx_gap_max;
	bit  hold_off_req;
	int  stall_cycles;

	// directed table
	logic [RADIX_W-1:0] dir_radix[$];
	logic [31:0]        dir_value[$];
	string              dir_text[$];

	integer_to_ascii_radix dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// expected text of one integer in the current base
	function automatic void predict_text(input logic [31:0] value, input logic [RADIX_W-1:0] reg_val);
		logic [RADIX_W-1:0] base;
		logic [RADIX_W-1:0] d;
		logic [32:0]        mag;
		logic [CHAR_W-1:0]  chars[$];
		logic               neg;
		text_char_t         tc;
		base = reg_val;
		if (base < RADIX_MIN) begin
			base = RADIX_MIN;
		end
		if (base > RADIX_MAX) begin
			base = RADIX_MAX;
		end
		neg = (base == DECIMAL) && value[31];
		// one bit wider so the most negative decimal value has a magnitude
		mag = neg ? (33'd0 - {value[31], value}) : {1'b0, value};
		if (mag == 33'd0) begin
			chars.push_front(CHR_ZERO);
		end
		while (mag != 33'd0) begin
			d = RADIX_W'(mag % base);
			chars.push_front((d > TOP_NUMERIC) ? CHR_LOWER_A + CHAR_W'(d - DECIMAL)
				: CHR_ZERO + CHAR_W'(d));
			mag = mag / base;
		end
		if (neg) begin
			chars.push_front(CHR_MINUS);
		end
		foreach (chars[k]) begin
			tc.ch   = chars[k];
			tc.last = (k == chars.size() - 1);
			pending_chars.push_back(tc);
		end
	endfunction

	// typed-in text for table rows
	function automatic void expect_text(input string txt);
		text_char_t tc;
		for (int k = 0; k < txt.len(); k++) begin
			tc.ch   = txt[k];
			tc.last = (k == txt.len() - 1);
			pending_chars.push_back(tc);
		end
	endfunction

	function automatic void add_row(input logic [RADIX_W-1:0] r, input logic [31:0] v,
		input string txt);
		dir_radix.push_back(r);
		dir_value.push_back(v);
		dir_text.push_back(txt);
	endfunction

	// integers with a spread of digit counts and both signs
	function automatic logic [31:0] rand_value(input logic [RADIX_W-1:0] reg_val);
		longint unsigned p;
		longint unsigned b;
		logic [31:0]     v;
		b = 64'((reg_val < RADIX_MIN) ? RADIX_MIN : (reg_val > RADIX_MAX) ? RADIX_MAX : reg_val);
		case ($urandom_range(0, 7))
			0: v = $urandom_range(0, 40);
			1: v = -$urandom_range(1, 40);
			2: v = $urandom >> $urandom_range(0, 31);
			3: v = -($urandom >> $urandom_range(0, 31));
			4: begin
				case ($urandom_range(0, 4))
					0: v = 32'h0;
					1: v = 32'h1;
					2: v = 32'hffff_ffff;
					3: v = 32'h7fff_ffff;
					default: v = 32'h8000_0000;
				endcase
			end
			5: begin
				// digit-count boundaries: a power of the base or one below it
				p = 1;
				repeat ($urandom_range(1, 31)) begin
					if (p * b < 64'h1_0000_0000) begin
						p = p * b;
					end
				end
				v = 32'(p - $urandom_range(0, 1));
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic push_value(input logic [31:0] v, input string txt);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = S_TDATA_W'(v);
		do @(posedge clk); while (!s_tready);
		if (txt.len() == 0) begin
			predict_text(v, radix_copy);
		end else begin
			expect_text(txt);
		end
	endtask

	// stop offering and wait for every owed character
	task automatic drain;
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	task automatic set_radix(input logic [RADIX_W-1:0] r);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = r;
		do @(posedge clk); while (!cfg_ready);
		radix_copy = r;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// output side: random stalls, one long hold-off on request
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end
			gap = $urandom_range(0, rx_gap_max);
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// compare each character word with the oldest expectation
	always @(posedge clk) begin
		text_char_t exp_c;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				err_count++;
				if (err_count <= 10) begin
					$display("unexpected word: char %h last %b", m_tdata, m_tlast);
				end
			end else begin
				exp_c = pending_chars.pop_front();
				if (m_tdata !== exp_c.ch || m_tlast !== exp_c.last) begin
					err_count++;
					if (err_count <= 10) begin
						$display("mismatch: expected char %h last %b, got char %h last %b",
							exp_c.ch, exp_c.last, m_tdata, m_tlast);
					end
				end
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		logic [RADIX_W-1:0] phase_radix[PHASES];
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		err_count    = 0;
		stall_cycles = 0;
		hold_off_req = 1'b0;
		tx_gap_max   = 4;
		rx_gap_max   = 4;
		radix_copy   = RADIX_RESET;

		// reset value of the radix, then extremes and saturation of the base
		add_row(6'd10, 32'd0, "0");
		add_row(6'd10, 32'd1, "1");
		add_row(6'd10, 32'hffff_ffff, "-1");
		add_row(6'd10, 32'h7fff_ffff, "2147483647");
		add_row(6'd10, 32'h8000_0000, "-2147483648");
		add_row(6'd10, 32'd1234567890, "");
		add_row(6'd10, -32'sd1000, "-1000");
		add_row(6'd2, 32'd0, "0");
		add_row(6'd2, 32'd5, "101");
		add_row(6'd2, 32'hffff_ffff, {"11111111", "11111111", "11111111", "11111111"});
		add_row(6'd2, 32'h8000_0000, {"10000000", "00000000", "00000000", "00000000"});
		add_row(6'd16, 32'hffff_ffff, "ffffffff");
		add_row(6'd16, 32'hdead_beef, "deadbeef");
		add_row(6'd16, 32'h7fff_ffff, "7fffffff");
		add_row(6'd36, 32'd35, "z");
		add_row(6'd36, 32'd36, "10");
		add_row(6'd36, 32'hffff_ffff, "");
		add_row(6'd36, 32'h8000_0000, "");
		add_row(6'd0, 32'd6, "110");
		add_row(6'd1, 32'd3, "11");
		add_row(6'd63, 32'd35, "z");
		add_row(6'd37, 32'd36, "10");
		add_row(6'd8, -32'sd8, "");
		add_row(6'd10, -32'sd42, "-42");

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (dir_value[i]) begin
			if (dir_radix[i] != radix_copy) begin
				drain();
				set_radix(dir_radix[i]);
			end
			push_value(dir_value[i], dir_text[i]);
		end

		// random phases, one base each
		phase_radix = '{6'd2, 6'd16, 6'd36, 6'd10, 6'd7, 6'd0, 6'd3, 6'd0};
		phase_radix[5] = RADIX_W'($urandom_range(0, 63));
		phase_radix[7] = RADIX_W'($urandom_range(0, 63));
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			set_radix(phase_radix[ph]);
			// one phase runs back to back on both sides
			tx_gap_max = (ph == 3) ? 0 : 4;
			rx_gap_max = (ph == 3) ? 0 : 4;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == 4) begin
					hold_off_req = 1'b1;
				end
				if (ph == 4 && n == 9) begin
					drain();
				end
				push_value(rand_value(radix_copy), "");
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
